### rtl/core/humidity_sensor_read_sequencer_macros.svh
// Assertion helpers used by the checker file.
`ifndef HUMIDITY_SENSOR_READ_SEQUENCER_MACROS_SVH
`define HUMIDITY_SENSOR_READ_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HSRS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hsrs: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define HSRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hsrs: next-cycle check failed");

`endif

### rtl/core/hsrs_pkg.sv
package hsrs_pkg;

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned HUM_W    = 14;
    localparam int unsigned TEMP_W   = 15;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 56;

    localparam logic [TICK_W-1:0] RESET_DELAY_DEFAULT    = 16'd5;
    localparam logic [TICK_W-1:0] TEMP_DELAY_DEFAULT     = 16'd7;
    localparam logic [TICK_W-1:0] HUMIDITY_DELAY_DEFAULT = 16'd17;

    // code * scale / 65536 - offset
    localparam int unsigned CODE_FRAC  = 16;
    localparam int unsigned HUM_SCALE  = 12500;
    localparam int unsigned HUM_OFFSET = 600;
    localparam int unsigned TMP_SCALE  = 17572;
    localparam int unsigned TMP_OFFSET = 4685;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DELAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY_DELAY = 2'd2;

    typedef enum logic [1:0] {
        MODE_RESET    = 2'd0,
        MODE_HUMIDITY = 2'd1,
        MODE_TEMP     = 2'd2,
        MODE_DONE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_BUS    = 2'd1,
        ACT_TIMER  = 2'd2,
        ACT_REPORT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        TR_RESET     = 3'd0,
        TR_START_HUM = 3'd1,
        TR_START_TMP = 3'd2,
        TR_READ_HUM  = 3'd3,
        TR_READ_TMP  = 3'd4
    } trans_t;

    typedef enum logic [1:0] {
        REP_RESET_DONE = 2'd0,
        REP_HUM_READY  = 2'd1,
        REP_TMP_READY  = 2'd2
    } report_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_START = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_HUM_START = 4'd3,
        PH_HUM_WAIT  = 4'd4,
        PH_HUM_READ  = 4'd5,
        PH_TMP_START = 4'd6,
        PH_TMP_WAIT  = 4'd7,
        PH_TMP_READ  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] reset_ticks;
        logic [TICK_W-1:0] temp_ticks;
        logic [TICK_W-1:0] humidity_ticks;
    } cfg_delays_t;

    typedef struct packed {
        action_t           action;
        trans_t            transaction;
        logic [TICK_W-1:0] delay_ticks;
        report_t           report;
        logic              use_humidity;
        logic              use_temperature;
    } cmd_t;

endpackage

### rtl/core/humidity_sensor_read_sequencer.sv
// Humidity/temperature sensor measurement sequencer.
// Input stream (s_*): one event per transfer. s_tuser carries the mode
// (request reset, humidity+temperature, temperature only, or completion);
// s_tdata carries the raw humidity and temperature codes used on the final
// completion of a read.
// Output stream (m_*): exactly one result per event. m_tuser carries the
// action (none, bus transaction, start timer, report); m_tdata carries the
// transaction kind, timer length, report kind and converted readings, all
// zero where the action does not use them.
// Config port (cfg_*): always ready; index 0 reset delay, 1 temperature
// delay, 2 humidity delay. Other indexes are dropped. Write only when idle.
// m_tvalid rises once the event has passed the input register and then the
// phase decode and constant multiplies into the output register.
// Throughput is one event per cycle while m_tready stays high; the phase
// register updates as each event moves into the output register.
// Reset clears both stages, sets the phase to idle and loads the default
// delays (5, 7, 17). When m_tready is low the result holds and the input
// stage still takes one more event before s_tready drops.
module humidity_sensor_read_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hsrs_pkg::S_TDATA_W-1:0]      s_tdata,  // humidity_code, temperature_code
    input  logic [1:0]                          s_tuser,  // mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // transaction, delay_ticks, report, humidity, temperature, zero pad
    output logic [hsrs_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                          m_tuser,  // action
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hsrs_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [hsrs_pkg::TICK_W-1:0]         cfg_data
);
    import hsrs_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    mode_t             in_mode_reg;
    logic [CODE_W-1:0] in_hum_reg;
    logic [CODE_W-1:0] in_tmp_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    action_t            out_action_reg;
    trans_t             out_trans_reg;
    logic [TICK_W-1:0]  out_delay_reg;
    report_t            out_report_reg;
    logic [HUM_W-1:0]   out_hum_reg;
    logic [TEMP_W-1:0]  out_tmp_reg;

    logic               out_free;
    logic               advance;
    cfg_delays_t        delays;
    cmd_t               cmd;
    logic [HUM_W-1:0]   conv_hum;
    logic signed [TEMP_W-1:0] conv_tmp;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;

    hsrs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .delays    (delays)
    );

    hsrs_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .mode    (in_mode_reg),
        .delays  (delays),
        .cmd     (cmd)
    );

    hsrs_conv u_conv (
        .humidity_code    (in_hum_reg),
        .temperature_code (in_tmp_reg),
        .humidity         (conv_hum),
        .temperature      (conv_tmp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= mode_t'(s_tuser);
            in_hum_reg  <= s_tdata[CODE_W-1:0];
            in_tmp_reg  <= s_tdata[2*CODE_W-1:CODE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_action_reg <= cmd.action;
            out_trans_reg  <= cmd.transaction;
            out_delay_reg  <= cmd.delay_ticks;
            out_report_reg <= cmd.report;
            out_hum_reg    <= cmd.use_humidity ? conv_hum : '0;
            out_tmp_reg    <= cmd.use_temperature ? unsigned'(conv_tmp) : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = {
        (M_TDATA_W-3-TICK_W-2-HUM_W-TEMP_W)'(0),
        out_tmp_reg,
        out_hum_reg,
        out_report_reg,
        out_delay_reg,
        out_trans_reg
    };

endmodule

### rtl/core/hsrs_cfg.sv
module hsrs_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hsrs_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [hsrs_pkg::TICK_W-1:0]    cfg_data,
    output hsrs_pkg::cfg_delays_t          delays
);
    import hsrs_pkg::*;

    cfg_delays_t delays_reg;
    cfg_delays_t delays_next;

    assign cfg_ready = 1'b1;
    assign delays    = delays_reg;

    always_comb begin
        delays_next = delays_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                CFG_RESET_DELAY:    delays_next.reset_ticks    = cfg_data;
                CFG_TEMP_DELAY:     delays_next.temp_ticks     = cfg_data;
                CFG_HUMIDITY_DELAY: delays_next.humidity_ticks = cfg_data;
                default:            delays_next = delays_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delays_reg.reset_ticks    <= RESET_DELAY_DEFAULT;
            delays_reg.temp_ticks     <= TEMP_DELAY_DEFAULT;
            delays_reg.humidity_ticks <= HUMIDITY_DELAY_DEFAULT;
        end else begin
            delays_reg <= delays_next;
        end
    end

endmodule

### rtl/core/hsrs_conv.sv
module hsrs_conv (
    input  logic [hsrs_pkg::CODE_W-1:0]        humidity_code,
    input  logic [hsrs_pkg::CODE_W-1:0]        temperature_code,
    output logic [hsrs_pkg::HUM_W-1:0]         humidity,
    output logic signed [hsrs_pkg::TEMP_W-1:0] temperature
);
    import hsrs_pkg::*;

    localparam int unsigned HUM_PROD_W = CODE_W + HUM_W;
    localparam int unsigned TMP_PROD_W = CODE_W + TEMP_W;

    logic [HUM_PROD_W-1:0] hum_prod;
    logic [TMP_PROD_W-1:0] tmp_prod;
    logic [HUM_W-1:0]      hum_scaled;
    logic [TEMP_W-1:0]     tmp_scaled;
    logic [TEMP_W:0]       tmp_diff;

    assign hum_prod   = HUM_PROD_W'(HUM_SCALE) * HUM_PROD_W'(humidity_code);
    assign tmp_prod   = TMP_PROD_W'(TMP_SCALE) * TMP_PROD_W'(temperature_code);
    assign hum_scaled = hum_prod[HUM_PROD_W-1:CODE_FRAC];
    assign tmp_scaled = tmp_prod[TMP_PROD_W-1:CODE_FRAC];

    // negative humidity clamps to zero
    assign humidity = (hum_scaled < HUM_W'(HUM_OFFSET)) ? '0
                    : hum_scaled - HUM_W'(HUM_OFFSET);

    assign tmp_diff    = {1'b0, tmp_scaled} - (TEMP_W+1)'(TMP_OFFSET);
    assign temperature = signed'(tmp_diff[TEMP_W-1:0]);

endmodule

### rtl/core/hsrs_fsm.sv
module hsrs_fsm (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  hsrs_pkg::mode_t       mode,
    input  hsrs_pkg::cfg_delays_t delays,
    output hsrs_pkg::cmd_t        cmd
);
    import hsrs_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (advance) begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        phase_next          = phase_reg;
        cmd.action          = ACT_NONE;
        cmd.transaction     = TR_RESET;
        cmd.delay_ticks     = '0;
        cmd.report          = REP_RESET_DONE;
        cmd.use_humidity    = 1'b0;
        cmd.use_temperature = 1'b0;
        case (mode)
            MODE_RESET: begin
                phase_next      = PH_RST_START;
                cmd.action      = ACT_BUS;
                cmd.transaction = TR_RESET;
            end
            MODE_HUMIDITY: begin
                phase_next      = PH_HUM_START;
                cmd.action      = ACT_BUS;
                cmd.transaction = TR_START_HUM;
            end
            MODE_TEMP: begin
                phase_next      = PH_TMP_START;
                cmd.action      = ACT_BUS;
                cmd.transaction = TR_START_TMP;
            end
            default: begin
                case (phase_reg)
                    PH_RST_START: begin
                        phase_next      = PH_RST_WAIT;
                        cmd.action      = ACT_TIMER;
                        cmd.delay_ticks = delays.reset_ticks;
                    end
                    PH_RST_WAIT: begin
                        phase_next = PH_IDLE;
                        cmd.action = ACT_REPORT;
                        cmd.report = REP_RESET_DONE;
                    end
                    PH_HUM_START: begin
                        phase_next      = PH_HUM_WAIT;
                        cmd.action      = ACT_TIMER;
                        cmd.delay_ticks = delays.humidity_ticks;
                    end
                    PH_HUM_WAIT: begin
                        phase_next      = PH_HUM_READ;
                        cmd.action      = ACT_BUS;
                        cmd.transaction = TR_READ_HUM;
                    end
                    PH_HUM_READ: begin
                        phase_next          = PH_IDLE;
                        cmd.action          = ACT_REPORT;
                        cmd.report          = REP_HUM_READY;
                        cmd.use_humidity    = 1'b1;
                        cmd.use_temperature = 1'b1;
                    end
                    PH_TMP_START: begin
                        phase_next      = PH_TMP_WAIT;
                        cmd.action      = ACT_TIMER;
                        cmd.delay_ticks = delays.temp_ticks;
                    end
                    PH_TMP_WAIT: begin
                        phase_next      = PH_TMP_READ;
                        cmd.action      = ACT_BUS;
                        cmd.transaction = TR_READ_TMP;
                    end
                    PH_TMP_READ: begin
                        phase_next          = PH_IDLE;
                        cmd.action          = ACT_REPORT;
                        cmd.report          = REP_TMP_READY;
                        cmd.use_temperature = 1'b1;
                    end
                    default: begin
                        // idle or corrupt phase: no action
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        endcase
    end

endmodule

### rtl/core/hsrs_checker.sv
`include "humidity_sensor_read_sequencer_macros.svh"

module hsrs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hsrs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                     m_tuser
);
    import hsrs_pkg::*;

    `HSRS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `HSRS_ASSERT_NOW(a_trans_only_on_bus, aclk, aresetn, m_tvalid && m_tuser != ACT_BUS, m_tdata[2:0] == 3'd0)
    `HSRS_ASSERT_NOW(a_delay_only_on_timer, aclk, aresetn, m_tvalid && m_tuser != ACT_TIMER, m_tdata[18:3] == 16'd0)
    `HSRS_ASSERT_NOW(a_report_fields, aclk, aresetn, m_tvalid && m_tuser != ACT_REPORT, m_tdata[55:19] == 37'd0)

endmodule

bind humidity_sensor_read_sequencer hsrs_checker u_hsrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/tb.sv
module tb;
    import hsrs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_EVENTS = 1000;

    typedef struct packed {
        action_t            act;
        trans_t             xact;
        logic [TICK_W-1:0]  ticks;
        report_t            rep;
        logic [HUM_W-1:0]   hum;
        logic [TEMP_W-1:0]  temp;
        logic [5:0]         pad;
    } sensor_result_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } rx_pattern_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
    logic [TICK_W-1:0]      cfg_data  = '0;

    phase_t                 model_phase;
    cfg_delays_t            model_delays;
    sensor_result_t         pending_results[$];
    int                     fail_count   = 0;
    int                     events_sent  = 0;
    int                     burst_left   = 0;
    int                     quiet_cycles = 0;
    int                     stall_left   = 0;
    rx_pattern_t            rx_pattern   = RX_OPEN;

    always #1 aclk = ~aclk;

    humidity_sensor_read_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    function automatic logic [HUM_W-1:0] humidity_centi(logic [CODE_W-1:0] code);
        int unsigned scaled;
        scaled = (HUM_SCALE * code) >> CODE_FRAC;
        if (scaled < HUM_OFFSET) begin
            return '0;
        end
        return HUM_W'(scaled - HUM_OFFSET);
    endfunction

    function automatic logic [TEMP_W-1:0] temperature_centi(logic [CODE_W-1:0] code);
        int unsigned scaled;
        int          t;
        scaled = (TMP_SCALE * code) >> CODE_FRAC;
        t = int'(scaled) - int'(TMP_OFFSET);
        return t[TEMP_W-1:0];
    endfunction

    // advances the phase and returns the action for one event
    function automatic sensor_result_t sequencer_step(mode_t mode, logic [CODE_W-1:0] hum_code,
                                                      logic [CODE_W-1:0] temp_code);
        sensor_result_t r;
        r = '0;
        case (mode)
            MODE_RESET: begin
                model_phase = PH_RST_START;
                r.act = ACT_BUS;
                r.xact = TR_RESET;
            end
            MODE_HUMIDITY: begin
                model_phase = PH_HUM_START;
                r.act = ACT_BUS;
                r.xact = TR_START_HUM;
            end
            MODE_TEMP: begin
                model_phase = PH_TMP_START;
                r.act = ACT_BUS;
                r.xact = TR_START_TMP;
            end
            default: begin
                case (model_phase)
                    PH_RST_START: begin
                        model_phase = PH_RST_WAIT;
                        r.act = ACT_TIMER;
                        r.ticks = model_delays.reset_ticks;
                    end
                    PH_RST_WAIT: begin
                        model_phase = PH_IDLE;
                        r.act = ACT_REPORT;
                        r.rep = REP_RESET_DONE;
                    end
                    PH_HUM_START: begin
                        model_phase = PH_HUM_WAIT;
                        r.act = ACT_TIMER;
                        r.ticks = model_delays.humidity_ticks;
                    end
                    PH_HUM_WAIT: begin
                        model_phase = PH_HUM_READ;
                        r.act = ACT_BUS;
                        r.xact = TR_READ_HUM;
                    end
                    PH_HUM_READ: begin
                        model_phase = PH_IDLE;
                        r.act = ACT_REPORT;
                        r.rep = REP_HUM_READY;
                        r.hum = humidity_centi(hum_code);
                        r.temp = temperature_centi(temp_code);
                    end
                    PH_TMP_START: begin
                        model_phase = PH_TMP_WAIT;
                        r.act = ACT_TIMER;
                        r.ticks = model_delays.temp_ticks;
                    end
                    PH_TMP_WAIT: begin
                        model_phase = PH_TMP_READ;
                        r.act = ACT_BUS;
                        r.xact = TR_READ_TMP;
                    end
                    PH_TMP_READ: begin
                        model_phase = PH_IDLE;
                        r.act = ACT_REPORT;
                        r.rep = REP_TMP_READY;
                        r.temp = temperature_centi(temp_code);
                    end
                    default: begin
                        model_phase = PH_IDLE;
                    end
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic string describe_result(sensor_result_t r);
        return $sformatf("act=%0d xact=%0d ticks=%0d rep=%0d hum=%0d temp=%0d pad=%0h",
                         r.act, r.xact, r.ticks, r.rep, r.hum, $signed(r.temp), r.pad);
    endfunction

    function automatic logic [CODE_W-1:0] random_code();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return CODE_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // sender: bursts of back-to-back transfers separated by random gaps
    task automatic send_event(mode_t mode, logic [CODE_W-1:0] hum_code,
                              logic [CODE_W-1:0] temp_code);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {temp_code, hum_code};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(sequencer_step(mode, hum_code, temp_code));
        events_sent++;
    endtask

    task automatic await_all_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // stray write to the unused index first, then the three delays
    task automatic program_delays(logic [TICK_W-1:0] rst_ticks, logic [TICK_W-1:0] tmp_ticks,
                                  logic [TICK_W-1:0] hum_ticks);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [TICK_W-1:0]    val [4];
        int                   i;
        idx = '{CFG_UNUSED, CFG_RESET_DELAY, CFG_TEMP_DELAY, CFG_HUMIDITY_DELAY};
        val = '{TICK_W'($urandom), rst_ticks, tmp_ticks, hum_ticks};
        await_all_results();
        for (i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                CFG_RESET_DELAY:    model_delays.reset_ticks = val[i];
                CFG_TEMP_DELAY:     model_delays.temp_ticks = val[i];
                CFG_HUMIDITY_DELAY: model_delays.humidity_ticks = val[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_sequence(mode_t request, int completions);
        int i;
        send_event(request, random_code(), random_code());
        for (i = 0; i < completions; i++) begin
            send_event(MODE_DONE, random_code(), random_code());
        end
    endtask

    task automatic read_humidity_pair(logic [CODE_W-1:0] hum_code, logic [CODE_W-1:0] temp_code);
        send_event(MODE_HUMIDITY, random_code(), random_code());
        send_event(MODE_DONE, random_code(), random_code());
        send_event(MODE_DONE, random_code(), random_code());
        send_event(MODE_DONE, hum_code, temp_code);
    endtask

    // mostly complete sequences; some cut short, some overrun, some noise
    task automatic random_sequence();
        mode_t request;
        int    steps;
        int    pick;
        int    i;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            for (i = 0; i < $urandom_range(1, 3); i++) begin
                send_event(mode_t'($urandom_range(0, 3)), random_code(), random_code());
            end
            return;
        end
        case ($urandom_range(0, 2))
            0:       request = MODE_RESET;
            1:       request = MODE_HUMIDITY;
            default: request = MODE_TEMP;
        endcase
        steps = (request == MODE_RESET) ? 2 : 3;
        if (pick < 17) begin
            steps = $urandom_range(0, steps - 1);
        end else if (pick < 25) begin
            steps += $urandom_range(1, 2);
        end
        run_sequence(request, steps);
    endtask

    task automatic test_default_sequences();
        send_event(MODE_DONE, 16'h1234, 16'h5678);     // completion while idle
        send_event(MODE_RESET, 16'h0000, 16'hFFFF);
        send_event(MODE_DONE, 16'hFFFF, 16'h0000);
        send_event(MODE_DONE, 16'hAAAA, 16'h5555);
        send_event(MODE_TEMP, 16'h5555, 16'hAAAA);
        send_event(MODE_DONE, 16'h0000, 16'h0000);
        send_event(MODE_DONE, 16'hFFFF, 16'hFFFF);
        send_event(MODE_DONE, 16'hFFFF, 16'd17474);    // temp-only: humidity stays zero
        // request mid-sequence restarts it
        send_event(MODE_HUMIDITY, 16'h0F0F, 16'hF0F0);
        send_event(MODE_DONE, 16'hF0F0, 16'h0F0F);
        send_event(MODE_TEMP, 16'h8000, 16'h8000);
        send_event(MODE_DONE, 16'h7FFF, 16'h7FFF);
    endtask

    task automatic test_conversion_limits();
        read_humidity_pair(16'h0000, 16'h0000);
        read_humidity_pair(16'hFFFF, 16'hFFFF);
        read_humidity_pair(16'd3146, 16'd17473);       // clamp edge, temp just below zero
    endtask

    task automatic test_delay_registers();
        program_delays(16'hFFFF, 16'h0000, 16'hFFFF);
        run_sequence(MODE_RESET, 2);
        run_sequence(MODE_HUMIDITY, 3);
        run_sequence(MODE_TEMP, 3);
        program_delays(16'h0000, 16'hFFFF, 16'h0000);
        run_sequence(MODE_RESET, 2);
        run_sequence(MODE_HUMIDITY, 3);
        run_sequence(MODE_TEMP, 3);
    endtask

    task automatic test_random_traffic();
        int round;
        int goal;
        for (round = 0; round < 4; round++) begin
            case (round)
                0: program_delays(TICK_W'($urandom), TICK_W'($urandom), TICK_W'($urandom));
                1: program_delays(16'h0000, 16'h0000, 16'h0000);
                2: program_delays(16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: program_delays(RESET_DELAY_DEFAULT, TEMP_DELAY_DEFAULT,
                                        HUMIDITY_DELAY_DEFAULT);
            endcase
            goal = events_sent + RANDOM_EVENTS / 4;
            if (round == 1) begin
                while (events_sent < goal - RANDOM_EVENTS / 8) random_sequence();
                await_all_results();
            end
            while (events_sent < goal) random_sequence();
        end
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 256);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (rx_pattern)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
            default:  m_tready <= ~m_tready;
        endcase
    end

    always @(posedge aclk) begin : result_check
        sensor_result_t got;
        sensor_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.act   = action_t'(m_tuser);
            got.xact  = trans_t'(m_tdata[2:0]);
            got.ticks = m_tdata[18:3];
            got.rep   = report_t'(m_tdata[20:19]);
            got.hum   = m_tdata[34:21];
            got.temp  = m_tdata[49:35];
            got.pad   = m_tdata[55:50];
            if (pending_results.size() == 0) begin
                note_failure({"unexpected result: ", describe_result(got)});
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    note_failure({"result mismatch: expected ", describe_result(want),
                                  " actual ", describe_result(got)});
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAIL humidity_sensor_read_sequencer");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        model_phase = PH_IDLE;
        model_delays.reset_ticks    = RESET_DELAY_DEFAULT;
        model_delays.temp_ticks     = TEMP_DELAY_DEFAULT;
        model_delays.humidity_ticks = HUMIDITY_DELAY_DEFAULT;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_sequences();
        test_conversion_limits();
        test_delay_registers();
        test_random_traffic();
        await_all_results();
        repeat (6) @(posedge aclk);
        if (pending_results.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (fail_count == 0) begin
            $display("PASS humidity_sensor_read_sequencer");
        end else begin
            $display("FAIL humidity_sensor_read_sequencer");
        end
        $finish;
    end

endmodule
